### hw/rtl/lup_pkg.sv
// Shared types, constants and fixed-point helpers for the LU factoring core.
// No dependencies; every other file but lup_ram imports this package.
package lup_pkg;

  localparam int MAX_SIZE    = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int ADDR_W      = 6;
  localparam int CELLS       = 64;
  localparam int ELEM_W      = 32;
  localparam int LOAD_W      = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_STRICT   = 2'd1;
  localparam logic [1:0] STATUS_SINGULAR = 2'd2;

  localparam logic [1:0] REG_SIZE   = 2'd0;
  localparam logic [1:0] REG_STRICT = 2'd1;
  localparam logic [1:0] REG_TOL    = 2'd2;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // Command word passed from the front to the back through the queue
  typedef struct packed {
    logic               do_load;
    logic               do_factor;
    logic [ADDR_W-1:0]  addr;
    logic signed [31:0] value;
    logic [LOAD_W-1:0]  count;
  } cmd_t;

  // Active configuration seen by the back
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             strict;
    logic [15:0]      tol;
  } cfg_t;

  // Magnitude of a signed 32-bit value as unsigned
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] u;
    u = x;
    if (x[31]) u = ~u + 32'd1;
    return u;
  endfunction

  // Apply sign to a 48-bit magnitude and saturate to 32 bits
  function automatic logic signed [31:0] sat_mag48(input logic neg, input logic [47:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      if (mag >= 48'h0000_8000_0000) r = 32'sh8000_0000;
      else r = -$signed(mag[31:0]);
    end else begin
      if (mag > 48'h0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

endpackage

### hw/rtl/lup_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/lup_queue.sv
// Short command queue between the front and the back.
// Depends on lup_pkg for cmd_t and the queue depth.
module lup_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lup_pkg::cmd_t push_cmd,
  input  logic          pop,
  output lup_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import lup_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Store words
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_cmd;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
    end
  end
endmodule

### hw/rtl/lup_front.sv
// Front end: accepts words, tracks the load position and issues commands.
// Depends on lup_pkg for cmd_t and widths.
module lup_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [31:0]       element_value,
  input  logic                     last_element,
  input  logic [lup_pkg::CNT_W-1:0] n,
  input  logic                     queue_full,
  input  logic                     done,
  output logic                     busy,
  output logic                     push,
  output lup_pkg::cmd_t            cmd
);
  import lup_pkg::*;

  logic [LOAD_W-1:0] load_count;
  logic              pending;
  logic [7:0]        sq;
  logic [LOAD_W-1:0] total;
  logic [LOAD_W-1:0] cnt_next;
  logic              trigger;
  logic [IDX_W-1:0]  row;
  logic [LOAD_W-1:0] rem;

  // Split a load position into row and column by repeated subtraction
  always_comb begin
    rem = load_count;
    row = '0;
    for (int s = 0; s < MAX_SIZE; s++) begin
      if (rem >= {3'b0, n}) begin
        rem = rem - {3'b0, n};
        row = row + 1'b1;
      end
    end
  end

  assign sq    = {4'b0, n} * {4'b0, n};
  assign total = sq[LOAD_W-1:0];
  assign busy  = queue_full || pending;
  assign push  = start && !busy;

  // Classify: store the element if room remains, factor when full or marked
  always_comb begin
    cmd.do_load = (load_count < total);
    cnt_next    = (load_count < total) ? load_count + 1'b1 : total;
    trigger     = (cnt_next >= total) || last_element;
    cmd.do_factor = trigger;
    cmd.addr    = {row, rem[IDX_W-1:0]};
    cmd.value   = element_value;
    cmd.count   = cnt_next;
  end

  // Hold load position; hold off new words while a factoring is out
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      pending    <= 1'b0;
    end else begin
      if (push) load_count <= trigger ? '0 : cnt_next;
      if (push && trigger) pending <= 1'b1;
      else if (done) pending <= 1'b0;
    end
  end
endmodule

### hw/rtl/lup_div.sv
// Restoring divider: (num << 16) / den, one quotient bit per cycle, saturated to Q16.16.
// Depends on lup_pkg for sat_mag48.
module lup_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        num,
  input  logic [31:0]        den,
  input  logic               neg,
  output logic               done,
  output logic signed [31:0] quot
);
  import lup_pkg::*;

  logic [47:0] dvd;
  logic [47:0] q;
  logic [31:0] rem;
  logic [32:0] rem_sh;
  logic [5:0]  steps;
  logic        running;
  logic        sign;

  assign rem_sh = {rem, dvd[47]};

  // One bit a cycle; pulse done with the saturated quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= 6'd0;
        dvd     <= {num, 16'b0};
        rem     <= '0;
        q       <= '0;
        sign    <= neg;
      end else if (running) begin
        dvd <= {dvd[46:0], 1'b0};
        if (rem_sh >= {1'b0, den}) begin
          rem <= 32'(rem_sh - {1'b0, den});
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          q   <= {q[46:0], 1'b0};
        end
        steps <= steps + 1'b1;
        if (steps == 6'd47) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quot = sat_mag48(sign, q);
endmodule

### hw/rtl/lup_back.sv
// Back end: sequencer that clears, pivots, eliminates, forms the determinant
// and streams results. Depends on lup_pkg, lup_ram and lup_div.
module lup_back (
  input  logic                       clk,
  input  logic                       rst,
  input  lup_pkg::cfg_t              cfg,
  input  logic                       q_empty,
  input  lup_pkg::cmd_t              q_head,
  output logic                       q_pop,
  output logic                       done,
  output logic                       result_valid,
  output logic [2:0]                 out_row,
  output logic [2:0]                 out_col,
  output logic signed [31:0]         lower_value,
  output logic signed [31:0]         upper_value,
  output logic [2:0]                 perm_col,
  output logic [1:0]                 status,
  output logic signed [63:0]         determinant,
  output logic                       last_result
);
  import lup_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FILL   = 5'd1;
  localparam logic [4:0] S_KSTART = 5'd2;
  localparam logic [4:0] S_SRINIT = 5'd3;
  localparam logic [4:0] S_SRRD   = 5'd4;
  localparam logic [4:0] S_SRCMP  = 5'd5;
  localparam logic [4:0] S_SW0    = 5'd6;
  localparam logic [4:0] S_SW1    = 5'd7;
  localparam logic [4:0] S_SW2    = 5'd8;
  localparam logic [4:0] S_SW3    = 5'd9;
  localparam logic [4:0] S_PM0    = 5'd10;
  localparam logic [4:0] S_PM1    = 5'd11;
  localparam logic [4:0] S_PIVRD  = 5'd12;
  localparam logic [4:0] S_PIV    = 5'd13;
  localparam logic [4:0] S_E0     = 5'd14;
  localparam logic [4:0] S_E1     = 5'd15;
  localparam logic [4:0] S_EW     = 5'd16;
  localparam logic [4:0] S_U0     = 5'd17;
  localparam logic [4:0] S_U1     = 5'd18;
  localparam logic [4:0] S_U2     = 5'd19;
  localparam logic [4:0] S_U3     = 5'd20;
  localparam logic [4:0] S_DT0    = 5'd21;
  localparam logic [4:0] S_DT1    = 5'd22;
  localparam logic [4:0] S_DT2    = 5'd23;
  localparam logic [4:0] S_DT3    = 5'd24;
  localparam logic [4:0] S_DFIN   = 5'd25;
  localparam logic [4:0] S_OUT    = 5'd26;

  logic [4:0]          state;
  logic [CNT_W-1:0]    k, i, j;
  logic [IDX_W-1:0]    best;
  logic [31:0]         bestmag;
  logic signed [31:0]  pivot;
  logic signed [31:0]  swap_a;
  logic                sel_l;
  logic signed [31:0]  lval;
  logic [63:0]         prod;
  logic [63:0]         prod_hi;
  logic                pneg;
  logic signed [31:0]  pval;
  logic signed [31:0]  wij;
  logic signed [63:0]  det;
  logic [31:0]         dmag;
  logic                dneg;
  logic                singular;
  logic                flip;
  logic [IDX_W-1:0]    perm [MAX_SIZE];
  logic [IDX_W-1:0]    perm_tmp;
  logic [ADDR_W:0]     fill_a;
  logic [LOAD_W-1:0]   fill_cnt;
  logic [1:0]          stat;

  // Output pipeline stage
  logic                p1_valid;
  logic [IDX_W-1:0]    p1_r, p1_c;
  logic                p1_last;

  // Memory ports
  logic                wm_we, lm_we;
  logic [ADDR_W-1:0]   wm_waddr, lm_waddr, rd_addr;
  logic signed [31:0]  wm_wdata, lm_wdata;
  logic [31:0]         wm_rdata, lm_rdata;
  logic signed [31:0]  wm_rd;
  logic signed [31:0]  sw_rd;

  // Shared multiplier
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         mul_p;

  // Divider
  logic                div_start, div_done;
  logic signed [31:0]  div_q;

  // Misc combinational
  logic [IDX_W-1:0]    fr, fc;
  logic [7:0]          lin;
  logic [63:0]         detmag;
  logic [95:0]         full96;
  logic [79:0]         dsh;
  logic                det_neg;
  logic signed [32:0]  diff;
  logic                last_issue;
  logic [CNT_W-1:0]    swap_lim;

  assign wm_rd  = $signed(wm_rdata);
  assign sw_rd  = sel_l ? $signed(lm_rdata) : wm_rd;
  assign fr     = fill_a[5:3];
  assign fc     = fill_a[2:0];
  assign lin    = {5'b0, fr} * {4'b0, cfg.n} + {5'b0, fc};
  assign detmag = det[63] ? (~det + 64'd1) : det;
  assign full96 = {prod_hi, 32'b0} + {32'b0, prod};
  assign dsh    = full96[95:16];
  assign det_neg = det[63] ^ dneg;
  assign diff   = {wij[31], wij} - {pval[31], pval};
  assign last_issue = (i == cfg.n - 1'b1) && (j == cfg.n - 1'b1);
  assign swap_lim = sel_l ? k : cfg.n;
  assign mul_p  = mul_a * mul_b;
  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign done   = (state == S_OUT) && last_issue;
  assign div_start = (state == S_E1);

  lup_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_work (
    .clk(clk), .we(wm_we), .waddr(wm_waddr), .wdata(wm_wdata),
    .raddr(rd_addr), .rdata(wm_rdata)
  );

  lup_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_lower (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .raddr(rd_addr), .rdata(lm_rdata)
  );

  lup_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(mag32(wm_rd)), .den(mag32(pivot)), .neg(wm_rd[31] ^ pivot[31]),
    .done(div_done), .quot(div_q)
  );

  // Drive memory ports and multiplier operands from the state
  always_comb begin
    wm_we    = 1'b0;
    wm_waddr = q_head.addr;
    wm_wdata = q_head.value;
    lm_we    = 1'b0;
    lm_waddr = fill_a[ADDR_W-1:0];
    lm_wdata = '0;
    rd_addr  = {k[IDX_W-1:0], k[IDX_W-1:0]};
    mul_a    = mag32(wm_rd);
    mul_b    = mag32(lval);
    case (state)
      S_IDLE: begin
        wm_we = q_pop && q_head.do_load;
      end
      S_FILL: begin
        wm_waddr = fill_a[ADDR_W-1:0];
        wm_wdata = '0;
        wm_we    = ({1'b0, fr} < cfg.n) && ({1'b0, fc} < cfg.n) && (lin >= {1'b0, fill_cnt});
        lm_we    = 1'b1;
      end
      S_SRRD: rd_addr = {i[IDX_W-1:0], k[IDX_W-1:0]};
      S_SW0:  rd_addr = {k[IDX_W-1:0], j[IDX_W-1:0]};
      S_SW1:  rd_addr = {best, j[IDX_W-1:0]};
      S_SW2: begin
        wm_waddr = {k[IDX_W-1:0], j[IDX_W-1:0]};
        lm_waddr = {k[IDX_W-1:0], j[IDX_W-1:0]};
        wm_wdata = sw_rd;
        lm_wdata = sw_rd;
        wm_we    = !sel_l;
        lm_we    = sel_l;
      end
      S_SW3: begin
        wm_waddr = {best, j[IDX_W-1:0]};
        lm_waddr = {best, j[IDX_W-1:0]};
        wm_wdata = swap_a;
        lm_wdata = swap_a;
        wm_we    = !sel_l;
        lm_we    = sel_l;
      end
      S_E0: rd_addr = {i[IDX_W-1:0], k[IDX_W-1:0]};
      S_EW: begin
        wm_waddr = {i[IDX_W-1:0], k[IDX_W-1:0]};
        lm_waddr = {i[IDX_W-1:0], k[IDX_W-1:0]};
        wm_wdata = '0;
        lm_wdata = div_q;
        wm_we    = div_done;
        lm_we    = div_done;
      end
      S_U0: rd_addr = {k[IDX_W-1:0], j[IDX_W-1:0]};
      S_U1: rd_addr = {i[IDX_W-1:0], j[IDX_W-1:0]};
      S_U3: begin
        wm_waddr = {i[IDX_W-1:0], j[IDX_W-1:0]};
        wm_we    = 1'b1;
        if (diff[32] != diff[31]) wm_wdata = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else wm_wdata = diff[31:0];
      end
      S_DT0: rd_addr = {i[IDX_W-1:0], i[IDX_W-1:0]};
      S_DT1: begin
        mul_a = detmag[31:0];
        mul_b = mag32(wm_rd);
      end
      S_DT2: begin
        mul_a = detmag[63:32];
        mul_b = dmag;
      end
      S_OUT: rd_addr = {i[IDX_W-1:0], j[IDX_W-1:0]};
      default: ;
    endcase
  end

  // Sequence the factoring
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p1_valid <= 1'b0;
      flip     <= 1'b0;
      for (int e = 0; e < MAX_SIZE; e++) perm[e] <= IDX_W'(e);
    end else begin
      p1_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop && q_head.do_factor) begin
            fill_a   <= '0;
            fill_cnt <= q_head.count;
            flip     <= 1'b0;
            stat     <= STATUS_OK;
            for (int e = 0; e < MAX_SIZE; e++) perm[e] <= IDX_W'(e);
            state    <= S_FILL;
          end
        end
        S_FILL: begin
          fill_a <= fill_a + 1'b1;
          if (fill_a[ADDR_W-1:0] == ADDR_W'(CELLS - 1)) begin
            k     <= '0;
            state <= S_KSTART;
          end
        end
        S_KSTART: begin
          if (k == cfg.n - 1'b1) begin
            i        <= '0;
            det      <= 64'sh0000_0001_0000_0000;
            singular <= 1'b0;
            state    <= S_DT0;
          end else if (cfg.strict) begin
            state <= S_PIVRD;
          end else begin
            best  <= k[IDX_W-1:0];
            state <= S_SRINIT;
          end
        end
        S_SRINIT: begin
          bestmag <= mag32(wm_rd);
          i       <= k + 1'b1;
          state   <= S_SRRD;
        end
        S_SRRD: begin
          if (i == cfg.n) begin
            if (best != k[IDX_W-1:0]) begin
              sel_l <= 1'b0;
              j     <= '0;
              state <= S_SW0;
            end else begin
              state <= S_PIVRD;
            end
          end else begin
            state <= S_SRCMP;
          end
        end
        S_SRCMP: begin
          if (mag32(wm_rd) > bestmag) begin
            bestmag <= mag32(wm_rd);
            best    <= i[IDX_W-1:0];
          end
          i     <= i + 1'b1;
          state <= S_SRRD;
        end
        S_SW0: begin
          if (j == swap_lim) begin
            if (!sel_l) begin
              sel_l <= 1'b1;
              j     <= '0;
            end else begin
              state <= S_PM0;
            end
          end else begin
            state <= S_SW1;
          end
        end
        S_SW1: begin
          swap_a <= sw_rd;
          state  <= S_SW2;
        end
        S_SW2: state <= S_SW3;
        S_SW3: begin
          j     <= j + 1'b1;
          state <= S_SW0;
        end
        S_PM0: begin
          perm_tmp <= perm[best];
          state    <= S_PM1;
        end
        S_PM1: begin
          perm[best]             <= perm[k[IDX_W-1:0]];
          perm[k[IDX_W-1:0]]     <= perm_tmp;
          flip                   <= !flip;
          state                  <= S_PIVRD;
        end
        S_PIVRD: state <= S_PIV;
        S_PIV: begin
          pivot <= wm_rd;
          if (mag32(wm_rd) <= {16'b0, cfg.tol}) begin
            if (cfg.strict) begin
              stat  <= STATUS_STRICT;
              det   <= '0;
              i     <= '0;
              j     <= '0;
              state <= S_OUT;
            end else begin
              k     <= k + 1'b1;
              state <= S_KSTART;
            end
          end else begin
            i     <= k + 1'b1;
            state <= S_E0;
          end
        end
        S_E0: begin
          if (i == cfg.n) begin
            k     <= k + 1'b1;
            state <= S_KSTART;
          end else begin
            state <= S_E1;
          end
        end
        S_E1: state <= S_EW;
        S_EW: begin
          if (div_done) begin
            lval  <= div_q;
            j     <= k + 1'b1;
            state <= S_U0;
          end
        end
        S_U0: begin
          if (j == cfg.n) begin
            i     <= i + 1'b1;
            state <= S_E0;
          end else begin
            state <= S_U1;
          end
        end
        S_U1: begin
          prod  <= mul_p;
          pneg  <= wm_rd[31] ^ lval[31];
          state <= S_U2;
        end
        S_U2: begin
          pval  <= sat_mag48(pneg, prod[63:16]);
          wij   <= wm_rd;
          state <= S_U3;
        end
        S_U3: begin
          j     <= j + 1'b1;
          state <= S_U0;
        end
        S_DT0: begin
          if (i == cfg.n) state <= S_DFIN;
          else state <= S_DT1;
        end
        S_DT1: begin
          dmag <= mag32(wm_rd);
          dneg <= wm_rd[31];
          if (mag32(wm_rd) <= {16'b0, cfg.tol}) singular <= 1'b1;
          prod  <= mul_p;
          state <= S_DT2;
        end
        S_DT2: begin
          prod_hi <= mul_p;
          state   <= S_DT3;
        end
        S_DT3: begin
          if (det_neg) begin
            if (dsh[79:63] != '0) det <= 64'sh8000_0000_0000_0000;
            else det <= -$signed(dsh[63:0]);
          end else begin
            if (dsh[79:63] != '0) det <= 64'sh7FFF_FFFF_FFFF_FFFF;
            else det <= $signed(dsh[63:0]);
          end
          i     <= i + 1'b1;
          state <= S_DT0;
        end
        S_DFIN: begin
          if (flip) begin
            if (det == 64'sh8000_0000_0000_0000) det <= 64'sh7FFF_FFFF_FFFF_FFFF;
            else det <= -det;
          end
          stat  <= singular ? STATUS_SINGULAR : STATUS_OK;
          i     <= '0;
          j     <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          p1_valid <= 1'b1;
          p1_r     <= i[IDX_W-1:0];
          p1_c     <= j[IDX_W-1:0];
          p1_last  <= last_issue;
          if (j == cfg.n - 1'b1) begin
            j <= '0;
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
          if (last_issue) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Register one result word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= p1_valid;
    end
    if (p1_valid) begin
      out_row     <= p1_r;
      out_col     <= p1_c;
      upper_value <= (p1_c >= p1_r) ? wm_rd : 32'sd0;
      if (p1_r == p1_c) lower_value <= ONE_Q16;
      else if (p1_r > p1_c) lower_value <= $signed(lm_rdata);
      else lower_value <= 32'sd0;
      perm_col    <= perm[p1_r];
      status      <= stat;
      determinant <= p1_last ? det : 64'sd0;
      last_result <= p1_last;
    end
  end
endmodule

### hw/rtl/lu_decomposition_partial_pivot_core.sv
// Top level of the LU factoring core: configuration registers and the
// front, queue and back. Depends on lup_pkg, lup_front, lup_queue, lup_back.
//
// Elements are taken one per cycle while the command queue has room; each is
// written into the matrix memory by the back. Once the matrix is complete
// (or an element is marked last) busy stays high while the back clears the
// unused cells and the lower-factor memory, factors the matrix and
// streams n*n result words, one per cycle, with no stall possible on the
// receiving side. Factoring time is set by the single-read-port matrix memory
// and the serial divider.
module lu_decomposition_partial_pivot_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] element_value,
  input  logic               last_element,
  output logic               result_valid,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] lower_value,
  output logic signed [31:0] upper_value,
  output logic [2:0]         perm_col,
  output logic [1:0]         status,
  output logic signed [63:0] determinant,
  output logic               last_result
);
  import lup_pkg::*;

  logic [3:0]  matrix_size;
  logic        strict_mode;
  logic [15:0] zero_tolerance;
  cfg_t        cfg;
  logic        apb_wr;
  logic        push, q_pop, q_empty, q_full, done;
  cmd_t        push_cmd, q_head;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size    <= 4'd8;
      strict_mode    <= 1'b0;
      zero_tolerance <= 16'd0;
    end else if (apb_wr) begin
      case (paddr[3:2])
        REG_SIZE:   matrix_size    <= pwdata[3:0];
        REG_STRICT: strict_mode    <= pwdata[0];
        REG_TOL:    zero_tolerance <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration
  always_comb begin
    case (paddr[3:2])
      REG_SIZE:   prdata = {28'b0, matrix_size};
      REG_STRICT: prdata = {31'b0, strict_mode};
      REG_TOL:    prdata = {16'b0, zero_tolerance};
      default:    prdata = '0;
    endcase
  end

  // Clamp size into the supported range
  always_comb begin
    if (matrix_size < 4'd2) cfg.n = 4'd2;
    else if (matrix_size > CNT_W'(MAX_SIZE)) cfg.n = CNT_W'(MAX_SIZE);
    else cfg.n = matrix_size;
    cfg.strict = strict_mode;
    cfg.tol    = zero_tolerance;
  end

  lup_front u_front (
    .clk(clk), .rst(rst), .start(start), .element_value(element_value),
    .last_element(last_element), .n(cfg.n), .queue_full(q_full), .done(done),
    .busy(busy), .push(push), .cmd(push_cmd)
  );

  lup_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .pop(q_pop),
    .head(q_head), .empty(q_empty), .full(q_full)
  );

  lup_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_head(q_head),
    .q_pop(q_pop), .done(done), .result_valid(result_valid),
    .out_row(out_row), .out_col(out_col), .lower_value(lower_value),
    .upper_value(upper_value), .perm_col(perm_col), .status(status),
    .determinant(determinant), .last_result(last_result)
  );

  // The last word of a matrix is never followed directly by another word
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !result_valid)
    else $error("result word right after last word");

  // Determinant only carried on the last word
  a_det_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |-> determinant == 64'sd0)
    else $error("determinant on non-last word");

  // Status stays the same across one matrix
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(result_valid) && !$past(last_result) |-> status == $past(status))
    else $error("status changed within a matrix");
endmodule
